// File: hdl/gelu_pkg.sv
// ----------------------------------------------------------------------------
// gelu_pkg
// Shared types and fixed-point constants for the GELU activation pipeline.
// ----------------------------------------------------------------------------
package gelu_pkg;

  // lookup table entries are unsigned Q16, 1.0 = 65536
  localparam int ROM_W = 17;
  localparam logic [ROM_W-1:0] ONE_Q16 = 17'h10000;

  // Q30 coefficients
  localparam logic [29:0] C_INV_SQRT2   = 30'd759250125;
  localparam logic [29:0] C_SQRT_2_PI   = 30'd856722023;
  localparam logic [25:0] C_CUBIC       = 26'd48012366;
  localparam logic [30:0] C_TWO_SQRT_PI = 31'd1211587905;
  localparam logic [29:0] HALF_Q30      = 30'h2000_0000;

  // table spans in units of 1.0, power of two
  localparam int ERF_SPAN       = 4;
  localparam int TANH_SPAN      = 8;
  localparam int ERF_SPAN_LOG2  = 2;
  localparam int TANH_SPAN_LOG2 = 3;

  // mode codes of the configuration register
  localparam logic MODE_ERF  = 1'b0;
  localparam logic MODE_TANH = 1'b1;

  // pipeline depth per section
  localparam int ARG_STAGES = 7;
  localparam int LUT_STAGES = 5;
  localparam int OUT_STAGES = 3;
  localparam int LATENCY    = ARG_STAGES + LUT_STAGES + OUT_STAGES;

  // control that travels with each item
  typedef struct packed {
    logic valid;
    logic neg;
    logic mode;
  } gelu_ctl_t;

endpackage

// File: hdl/gelu_activation.sv
// ----------------------------------------------------------------------------
// gelu_activation
// GELU on signed fixed-point samples, erf form or tanh cubic form, one item
// per clock outside reset through a fixed-latency pipeline.
// ----------------------------------------------------------------------------
//
//   channel   signals                        direction  transfer
//   -------   ----------------------------   ---------  -----------------------
//   config    cfg_we, cfg_data               in         edge with cfg_we high
//   input     start, busy, x_in              in / out   edge with start & !busy
//   result    done, y_out                    out        one cycle, done high
//
// An item is taken in every cycle outside reset; its result passes through
// the argument, lookup and output sections, whose depths add up to LATENCY
// (7 argument stages, 5 lookup stages, 3 output stages).
// The depth is set by the tanh argument chain of four multiplies: square,
// cube, cubic coefficient and sqrt(2/pi) scale, one per stage.
// rst is synchronous; busy is high while rst is high and low otherwise.
// Results carry no handshake back, so the pipeline never stalls.
module gelu_activation #(
  parameter int DATA_WIDTH    = 16,
  parameter int FRAC_BITS     = 12,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_data,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] x_in,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] y_out
);
  import gelu_pkg::*;

  localparam int Z_WIDTH = (DATA_WIDTH > FRAC_BITS + 6) ? DATA_WIDTH : FRAC_BITS + 6;

  logic                  use_tanh_approx;
  logic                  in_valid;
  gelu_ctl_t             arg_ctl, lut_ctl;
  logic [DATA_WIDTH-1:0] arg_mag, lut_mag;
  logic [Z_WIDTH-1:0]    arg_z;
  logic [ROM_W-1:0]      lut_p;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      use_tanh_approx <= MODE_ERF;
    end else if (cfg_we) begin
      use_tanh_approx <= cfg_data;
    end
  end

  // input acceptance
  assign busy     = rst;
  assign in_valid = start && !busy;

  gelu_arg #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .Z_WIDTH    (Z_WIDTH)
  ) u_arg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_mode  (use_tanh_approx),
    .x        (x_in),
    .ctl_o    (arg_ctl),
    .mag_o    (arg_mag),
    .z_o      (arg_z)
  );

  gelu_lut #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRAC_BITS     (FRAC_BITS),
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .Z_WIDTH       (Z_WIDTH)
  ) u_lut (
    .clk   (clk),
    .rst   (rst),
    .ctl_i (arg_ctl),
    .mag_i (arg_mag),
    .z_i   (arg_z),
    .ctl_o (lut_ctl),
    .mag_o (lut_mag),
    .p_o   (lut_p)
  );

  gelu_out #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_out (
    .clk   (clk),
    .rst   (rst),
    .ctl_i (lut_ctl),
    .mag_i (lut_mag),
    .p_i   (lut_p),
    .done  (done),
    .y     (y_out)
  );

endmodule

// File: hdl/gelu_arg.sv
// ----------------------------------------------------------------------------
// gelu_arg
// Takes the magnitude of x and forms the lookup argument z: x/sqrt2 for the
// erf form, sqrt(2/pi)*(x + 0.044715*x^3) for the tanh form.
// ----------------------------------------------------------------------------
module gelu_arg #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 12,
  parameter int Z_WIDTH    = 18
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_mode,
  input  logic signed [DATA_WIDTH-1:0]  x,
  output gelu_pkg::gelu_ctl_t           ctl_o,
  output logic [DATA_WIDTH-1:0]         mag_o,
  output logic [Z_WIDTH-1:0]            z_o
);
  import gelu_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int XW  = (DW > F + 4) ? DW : F + 4;
  localparam int MCW = (DW < F + 4) ? DW : F + 4;
  localparam int SQW = 2 * MCW;
  localparam int M2W = (SQW < F + 7) ? SQW : F + 7;
  localparam int CUW = M2W + MCW;
  localparam int M3W = (CUW < F + 10) ? CUW : F + 10;
  localparam int TW  = M3W + 26;
  localparam int IW  = F + 6;
  localparam int PEW = DW + 30;
  localparam int ZPW = IW + 30;
  localparam logic [XW-1:0] CLAMP = XW'(8) << F;

  logic [DW-1:0]  x_u;
  logic           neg0;
  logic [DW-1:0]  m0;
  logic [MCW-1:0] mc0;

  gelu_ctl_t      ctl_q [1:ARG_STAGES];
  logic [DW-1:0]  m_q   [1:ARG_STAGES];

  logic [MCW-1:0] mc1, mc2, mc3, mc4;
  logic [PEW-1:0] pe2;
  logic [SQW-1:0] sq2;
  logic [DW-1:0]  ze3, ze4, ze5, ze6;
  logic [CUW-1:0] cu3;
  logic [TW-1:0]  t4;
  logic [IW-1:0]  inner5;
  logic [ZPW-1:0] zp6;
  logic [Z_WIDTH-1:0] z7;

  // magnitude and cube clamp at 8.0
  assign x_u  = x;
  assign neg0 = x_u[DW-1];
  assign m0   = neg0 ? (~x_u + 1'b1) : x_u;
  assign mc0  = (XW'(m0) < CLAMP) ? MCW'(m0) : MCW'(CLAMP);

  // control shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= ARG_STAGES; i++) begin
        ctl_q[i] <= '0;
      end
    end else begin
      ctl_q[1] <= '{valid: in_valid, neg: neg0, mode: in_mode};
      for (int i = 2; i <= ARG_STAGES; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    m_q[1] <= m0;
    for (int i = 2; i <= ARG_STAGES; i++) begin
      m_q[i] <= m_q[i-1];
    end
    // stage 1
    mc1 <= mc0;
    // stage 2: x/sqrt2 product and square
    pe2 <= PEW'(m_q[1]) * PEW'(C_INV_SQRT2);
    sq2 <= SQW'(mc1) * SQW'(mc1);
    mc2 <= mc1;
    // stage 3: round erf argument, cube
    ze3 <= DW'(({1'b0, pe2} + (PEW+1)'(HALF_Q30)) >> 30);
    cu3 <= CUW'(M2W'(sq2 >> F)) * CUW'(mc2);
    mc3 <= mc2;
    // stage 4: cubic coefficient
    ze4 <= ze3;
    t4  <= TW'(M3W'(cu3 >> F)) * TW'(C_CUBIC);
    mc4 <= mc3;
    // stage 5: inner sum
    ze5    <= ze4;
    inner5 <= IW'(mc4) + IW'(({1'b0, t4} + (TW+1)'(HALF_Q30)) >> 30);
    // stage 6: sqrt(2/pi) scale
    ze6 <= ze5;
    zp6 <= ZPW'(inner5) * ZPW'(C_SQRT_2_PI);
    // stage 7: pick argument by mode
    if (ctl_q[6].mode == MODE_TANH) begin
      z7 <= Z_WIDTH'(({1'b0, zp6} + (ZPW+1)'(HALF_Q30)) >> 30);
    end else begin
      z7 <= Z_WIDTH'(ze6);
    end
  end

  assign ctl_o = ctl_q[ARG_STAGES];
  assign mag_o = m_q[ARG_STAGES];
  assign z_o   = z7;

endmodule

// File: hdl/gelu_lut.sv
// ----------------------------------------------------------------------------
// gelu_lut
// Interpolated table lookup of erf(z) or tanh(z) for z >= 0, clamped to 1.0
// past the table span. Tables are built at elaboration.
// ----------------------------------------------------------------------------
module gelu_lut #(
  parameter int DATA_WIDTH    = 16,
  parameter int FRAC_BITS     = 12,
  parameter int TABLE_ENTRIES = 256,
  parameter int Z_WIDTH       = 18
) (
  input  logic                         clk,
  input  logic                         rst,
  input  gelu_pkg::gelu_ctl_t          ctl_i,
  input  logic [DATA_WIDTH-1:0]        mag_i,
  input  logic [Z_WIDTH-1:0]           z_i,
  output gelu_pkg::gelu_ctl_t          ctl_o,
  output logic [DATA_WIDTH-1:0]        mag_o,
  output logic [gelu_pkg::ROM_W-1:0]   p_o
);
  import gelu_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int NB   = $clog2(TABLE_ENTRIES + 1);
  localparam int ZLW  = F + 3;
  localparam int NUMW = ZLW + NB;
  localparam int IXW  = $clog2(TABLE_ENTRIES);
  localparam int RIW  = NB;
  localparam int RW   = F + 3;
  localparam int PRW  = ROM_W + 1 + RW + 1;
  localparam logic [Z_WIDTH-1:0] DEN_E = Z_WIDTH'(ERF_SPAN) << F;
  localparam logic [Z_WIDTH-1:0] DEN_T = Z_WIDTH'(TANH_SPAN) << F;
  localparam logic signed [PRW-1:0] DENM_E = (PRW'(1) << (F + ERF_SPAN_LOG2)) - PRW'(1);
  localparam logic signed [PRW-1:0] DENM_T = (PRW'(1) << (F + TANH_SPAN_LOG2)) - PRW'(1);

  typedef logic [TABLE_ENTRIES:0][ROM_W-1:0] rom_t;

  // unsigned quotient by shift and subtract, used only while building tables
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-u), u in Q30: taylor series of e^(u/32), inverted, squared five times
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] u);
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    f    = u >> 5;
    term = 64'd1 << 30;
    sum  = 64'd1 << 30;
    for (int k = 1; k < 40; k++) begin
      if (term != 64'd0) begin
        term = udiv64(term * f, 64'(k) << 30);
        sum  = sum + term;
      end
    end
    v = udiv64(64'd1 << 60, sum);
    for (int j = 0; j < 5; j++) begin
      v = (v * v + (64'd1 << 29)) >> 30;
    end
    return v;
  endfunction

  // exp(-s^2) at the k-th half-step of the erf span
  function automatic logic [63:0] erf_point(input int k);
    logic [63:0] s;
    s = udiv64((64'(k) * 64'(ERF_SPAN)) << 24, 64'(2 * TABLE_ENTRIES));
    return exp_neg_q30((s * s) >> 18);
  endfunction

  // tanh(t) = (1 - e^-2t) / (1 + e^-2t)
  function automatic rom_t tanh_rom_f();
    rom_t        r;
    logic [63:0] u;
    logic [63:0] v;
    logic [63:0] th;
    r = '0;
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      u  = udiv64((64'(i) * 64'(2 * TANH_SPAN)) << 30, 64'(TABLE_ENTRIES));
      v  = exp_neg_q30(u);
      th = udiv64(((64'd1 << 30) - v) << 30, (64'd1 << 30) + v);
      r[i] = ROM_W'((th + 64'd8192) >> 14);
    end
    return r;
  endfunction

  // erf by cumulative simpson integration, clamped to 1.0
  function automatic rom_t erf_rom_f();
    rom_t        r;
    logic [63:0] h;
    logic [63:0] acc;
    logic [63:0] g0;
    logic [63:0] g1;
    logic [63:0] g2;
    logic [63:0] sum;
    logic [63:0] e;
    r   = '0;
    h   = udiv64(64'(ERF_SPAN) << 30, 64'(TABLE_ENTRIES));
    acc = 64'd0;
    g0  = erf_point(0);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      g1  = erf_point(2 * i + 1);
      g2  = erf_point(2 * i + 2);
      sum = g0 + 64'd4 * g1 + g2;
      acc = acc + udiv64((sum * h) >> 30, 64'd6);
      e   = (acc * 64'(C_TWO_SQRT_PI) + (64'd1 << 29)) >> 30;
      if (e > (64'd1 << 30)) begin
        e = 64'd1 << 30;
      end
      r[i+1] = ROM_W'((e + 64'd8192) >> 14);
      g0 = g2;
    end
    return r;
  endfunction

  localparam rom_t ERF_ROM  = erf_rom_f();
  localparam rom_t TANH_ROM = tanh_rom_f();

  gelu_ctl_t              ctl_q [1:LUT_STAGES];
  logic [DATA_WIDTH-1:0]  m_q   [1:LUT_STAGES];

  logic                   over1, over2, over3, over4;
  logic [NUMW-1:0]        num1;
  logic [IXW-1:0]         idx2;
  logic [RW-1:0]          rem2, rem3;
  logic [RIW-1:0]         ia, ib;
  logic [ROM_W-1:0]       rom_a, rom_b;
  logic [ROM_W-1:0]       a3, b3, a4;
  logic signed [ROM_W:0]  d3;
  logic signed [PRW-1:0]  prod4;
  logic signed [PRW-1:0]  adj4, quo4;
  logic [ROM_W-1:0]       p5;

  // control shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= LUT_STAGES; i++) begin
        ctl_q[i] <= '0;
      end
    end else begin
      ctl_q[1] <= ctl_i;
      for (int i = 2; i <= LUT_STAGES; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  // table read addresses
  assign ia    = RIW'(idx2);
  assign ib    = RIW'(idx2) + RIW'(1);
  assign rom_a = (ctl_q[2].mode == MODE_TANH) ? TANH_ROM[ia] : ERF_ROM[ia];
  assign rom_b = (ctl_q[2].mode == MODE_TANH) ? TANH_ROM[ib] : ERF_ROM[ib];

  // slope between neighbors, may be negative
  assign d3 = $signed({1'b0, b3}) - $signed({1'b0, a3});

  // divide by the span, rounding toward zero
  always_comb begin
    adj4 = prod4;
    if (prod4 < 0) begin
      adj4 = prod4 + ((ctl_q[4].mode == MODE_TANH) ? DENM_T : DENM_E);
    end
    if (ctl_q[4].mode == MODE_TANH) begin
      quo4 = adj4 >>> (F + TANH_SPAN_LOG2);
    end else begin
      quo4 = adj4 >>> (F + ERF_SPAN_LOG2);
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    m_q[1] <= mag_i;
    for (int i = 2; i <= LUT_STAGES; i++) begin
      m_q[i] <= m_q[i-1];
    end
    // stage 1: span check, scale by entry count
    if (ctl_i.mode == MODE_TANH) begin
      over1 <= (z_i >= DEN_T);
    end else begin
      over1 <= (z_i >= DEN_E);
    end
    num1 <= NUMW'(z_i[ZLW-1:0]) * NUMW'(TABLE_ENTRIES);
    // stage 2: split into entry index and remainder
    over2 <= over1;
    if (ctl_q[1].mode == MODE_TANH) begin
      idx2 <= IXW'(num1 >> (F + TANH_SPAN_LOG2));
      rem2 <= RW'(num1[F+TANH_SPAN_LOG2-1:0]);
    end else begin
      idx2 <= IXW'(num1 >> (F + ERF_SPAN_LOG2));
      rem2 <= RW'(num1[F+ERF_SPAN_LOG2-1:0]);
    end
    // stage 3: table read
    over3 <= over2;
    rem3  <= rem2;
    a3    <= rom_a;
    b3    <= rom_b;
    // stage 4: slope times remainder
    over4 <= over3;
    a4    <= a3;
    prod4 <= PRW'(d3) * PRW'($signed({1'b0, rem3}));
    // stage 5: interpolated value, or 1.0 past the span
    if (over4) begin
      p5 <= ONE_Q16;
    end else begin
      p5 <= ROM_W'(PRW'(a4) + quo4);
    end
  end

  assign ctl_o = ctl_q[LUT_STAGES];
  assign mag_o = m_q[LUT_STAGES];
  assign p_o   = p5;

endmodule

// File: hdl/gelu_out.sv
// ----------------------------------------------------------------------------
// gelu_out
// Forms y = 0.5*x*(1 +- phi) from |x| and the table value, restores the sign
// and saturates to the output range.
// ----------------------------------------------------------------------------
module gelu_out #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  gelu_pkg::gelu_ctl_t          ctl_i,
  input  logic [DATA_WIDTH-1:0]        mag_i,
  input  logic [gelu_pkg::ROM_W-1:0]   p_i,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] y
);
  import gelu_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int QW   = ROM_W + 1;
  localparam int PMW  = DW + QW;
  localparam int MAGW = PMW + 1;
  localparam logic [MAGW-1:0] HALF     = MAGW'(1) << (DW - 1);
  localparam logic [MAGW-1:0] HALF_M1  = HALF - MAGW'(1);
  localparam logic [MAGW-1:0] RND_Q17  = MAGW'(1) << 16;

  gelu_ctl_t        ctl_q [1:OUT_STAGES];
  logic [DW-1:0]    m1;
  logic [QW-1:0]    q1;
  logic [PMW-1:0]   pm2;
  logic [MAGW-1:0]  mag2;
  logic [MAGW-1:0]  sat2;
  logic [DW-1:0]    y_next;
  logic [DW-1:0]    y3;

  // control shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= OUT_STAGES; i++) begin
        ctl_q[i] <= '0;
      end
    end else begin
      ctl_q[1] <= ctl_i;
      for (int i = 2; i <= OUT_STAGES; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  // round, saturate and restore sign
  always_comb begin
    mag2 = ({1'b0, pm2} + RND_Q17) >> 17;
    if (ctl_q[2].neg) begin
      sat2   = (mag2 > HALF) ? HALF : mag2;
      y_next = ~DW'(sat2) + 1'b1;
    end else begin
      sat2   = (mag2 > HALF_M1) ? HALF_M1 : mag2;
      y_next = DW'(sat2);
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    // stage 1: 1 +- phi in Q16
    m1 <= mag_i;
    if (ctl_i.neg) begin
      q1 <= QW'(ONE_Q16) - QW'(p_i);
    end else begin
      q1 <= QW'(ONE_Q16) + QW'(p_i);
    end
    // stage 2: scale |x|
    pm2 <= PMW'(m1) * PMW'(q1);
    // stage 3: output register
    y3 <= y_next;
  end

  assign done = ctl_q[OUT_STAGES].valid;
  assign y    = y3;

endmodule

// File: hdl/gelu_chk.sv
// ----------------------------------------------------------------------------
// gelu_chk
// Port-level checks of the GELU pipeline: fixed latency, sign behavior and zero.
// ----------------------------------------------------------------------------
module gelu_chk #(
  parameter int DATA_WIDTH = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic signed [DATA_WIDTH-1:0] x_in,
  input logic                         done,
  input logic signed [DATA_WIDTH-1:0] y_out
);
  import gelu_pkg::*;

  // every accepted item gives exactly one result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy, LATENCY))
    else $error("result strobe does not match accepted item");

  // nonnegative input gives nonnegative result
  a_sign_pos: assert property (@(posedge clk) disable iff (rst)
    done && !$past(x_in[DATA_WIDTH-1], LATENCY) |-> !y_out[DATA_WIDTH-1])
    else $error("negative result for nonnegative item");

  // negative input gives a result that is negative or zero
  a_sign_neg: assert property (@(posedge clk) disable iff (rst)
    done && $past(x_in[DATA_WIDTH-1], LATENCY) |-> y_out[DATA_WIDTH-1] || y_out == '0)
    else $error("positive result for negative item");

  // zero maps to zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    done && $past(x_in, LATENCY) == '0 |-> y_out == '0)
    else $error("nonzero result for zero item");

endmodule

bind gelu_activation gelu_chk #(.DATA_WIDTH(DATA_WIDTH)) u_chk (.*);
